FILE: rtl/core/double_to_fixed_decimal_digits_defines.svh
// assertion helpers for the asserting converter module
`ifndef DOUBLE_TO_FIXED_DECIMAL_DIGITS_DEFINES_SVH
`define DOUBLE_TO_FIXED_DECIMAL_DIGITS_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define DTFD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the following cycle
`define DTFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/dtfd_pkg.sv
package dtfd_pkg;

    localparam int MAX_PRECISION     = 43;
    localparam int MAX_INT_DIGITS    = 20;
    localparam int DEFAULT_PRECISION = 6;

    localparam int PREC_W = 6;
    localparam int CHAR_W = 6;
    localparam int BCD_W  = 4 * MAX_INT_DIGITS;
    localparam int ND_W   = $clog2(MAX_INT_DIGITS + 1);

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_DOT  = 6'd46;

    typedef logic [63:0] t_rnd_table [0:MAX_PRECISION];

    // 0.5 divided by ten p times, each step rounded as binary64
    function automatic t_rnd_table build_rnd_table();
        real        r;
        t_rnd_table t;
        r = 0.5;
        for (int p = 0; p <= MAX_PRECISION; p++) begin
            t[p] = $realtobits(r);
            r = r / 10.0;
        end
        return t;
    endfunction

    localparam t_rnd_table RND_TABLE = build_rnd_table();

endpackage

FILE: rtl/core/double_to_fixed_decimal_digits.sv
// Converts a binary64 bit pattern to its %f decimal text, one character per beat.
// Input channel: i_in_valid / o_in_ready with value bits, precision and a flag
// telling whether the precision was given (otherwise six digits are used).
// Output channel: o_out_valid / i_out_ready; each beat carries one character
// ('0'..'9' or '.'), the sign flag, the out-of-range flag and last.
// Characters: integer digits, '.', then the fraction digits. NaN, infinity and
// magnitudes of 2^64 or more give a single '0' beat with out_of_range and last.
// Steps: after the accept, the rounding add runs in S_ALIGN and S_ROUND, the integer
// part is loaded in S_IPART and converted by shift-and-add-3 over its 64 bits,
// then S_SKIP drops leading zeros; each integer digit and the '.' is one beat.
// Each fraction digit passes S_FSUB, S_FNORM, S_FMUL and S_FDIG, with S_FNORM
// shifting the shared mantissa register left one bit at a time to normalize it.
// The block takes one number at a time: o_in_ready is high only while idle.
// A stalled receiver holds the pending beat in the output register and the
// sequencer waits; no beat is dropped. Reset returns to idle with no beat pending.
`include "double_to_fixed_decimal_digits_defines.svh"
module double_to_fixed_decimal_digits (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [63:0]                  i_value_bits,
    input  logic [dtfd_pkg::PREC_W-1:0]  i_precision,
    input  logic                         i_precision_given,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [dtfd_pkg::CHAR_W-1:0]  o_character,
    output logic                         o_is_negative,
    output logic                         o_out_of_range,
    output logic                         o_last
);
    import dtfd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_ALIGN, S_ROUND, S_IPART, S_DABBLE, S_SKIP, S_INT, S_DOT,
        S_FSUB, S_FNORM, S_FMUL, S_FDIG, S_OOR
    } t_state;

    typedef struct packed {
        logic [52:0] m;
        logic [1:0]  inc;
    } t_rnd;

    // round a 57-bit significand whose leading one is at bit 56 or 55 to 53 bits
    function automatic t_rnd round57(input logic [56:0] p);
        logic [52:0] mant;
        logic        g;
        logic        s;
        logic [53:0] up;
        t_rnd        res;
        if (p[56]) begin
            mant = p[56:4];
            g    = p[3];
            s    = |p[2:0];
        end else begin
            mant = p[55:3];
            g    = p[2];
            s    = |p[1:0];
        end
        up = {1'b0, mant} + {53'd0, g & (s | mant[0])};
        res.m   = up[53] ? {1'b1, 52'd0} : up[52:0];
        res.inc = {1'b0, p[56]} + {1'b0, up[53]};
        return res;
    endfunction

    t_state              r_state;
    logic [52:0]         r_m;
    logic signed [11:0]  r_e;
    logic [56:0]         r_sum;
    logic                r_neg;
    logic [PREC_W-1:0]   r_prec;
    logic [PREC_W-1:0]   r_j;
    logic [63:0]         r_bin;
    logic [BCD_W-1:0]    r_bcd;
    logic [6:0]          r_cnt;
    logic [ND_W-1:0]     r_nd;
    logic                r_out_valid;
    logic [CHAR_W-1:0]   r_char;
    logic                r_out_neg;
    logic                r_out_oor;
    logic                r_last;

    // input decode
    logic [10:0]         w_ef;
    logic signed [11:0]  w_in_e;
    logic                w_in_nan;
    logic                w_in_neg;
    logic [PREC_W-1:0]   w_prec;

    // alignment
    logic [63:0]         w_rnd;
    logic signed [11:0]  w_re;
    logic                w_num_big;
    logic [52:0]         w_big_m;
    logic [52:0]         w_sm_m;
    logic signed [11:0]  w_big_e;
    logic [11:0]         w_d;
    logic [55:0]         w_ext;
    logic [55:0]         w_shd;
    logic                w_stk;
    logic [56:0]         w_sum;

    logic                w_slot;
    logic                w_emit;
    t_rnd                w_rr;
    logic signed [11:0]  w_e_round;
    logic signed [11:0]  w_sa_tmp;
    logic [63:0]         w_ip;
    logic [BCD_W-1:0]    w_bcd_adj;
    logic [52:0]         w_keep;
    logic [56:0]         w_prod;
    t_rnd                w_mr;
    logic [3:0]          w_dig_raw;
    logic [3:0]          w_dig;
    logic [3:0]          w_top;

    assign w_slot = !r_out_valid || i_out_ready;
    assign w_emit = w_slot && (r_state inside {S_INT, S_DOT, S_FDIG, S_OOR});
    assign w_top  = r_bcd[BCD_W-1 -: 4];

    always_comb begin
        w_ef     = i_value_bits[62:52];
        w_in_e   = (w_ef == 11'd0) ? -12'sd1022 : ($signed({1'b0, w_ef}) - 12'sd1023);
        w_in_nan = (w_ef == 11'h7FF) && (i_value_bits[51:0] != 52'd0);
        w_in_neg = i_value_bits[63] && !w_in_nan && (i_value_bits[62:0] != 63'd0);
        if (!i_precision_given) begin
            w_prec = PREC_W'(DEFAULT_PRECISION);
        end else if (i_precision > PREC_W'(MAX_PRECISION)) begin
            w_prec = PREC_W'(MAX_PRECISION);
        end else begin
            w_prec = i_precision;
        end
    end

    always_comb begin
        w_rnd     = RND_TABLE[r_prec];
        w_re      = $signed({1'b0, w_rnd[62:52]}) - 12'sd1023;
        w_num_big = (r_e >= w_re);
        w_big_m   = w_num_big ? r_m : {1'b1, w_rnd[51:0]};
        w_sm_m    = w_num_big ? {1'b1, w_rnd[51:0]} : r_m;
        w_big_e   = w_num_big ? r_e : w_re;
        w_d       = w_num_big ? 12'(r_e - w_re) : 12'(w_re - r_e);
        w_ext     = {w_sm_m, 3'b000};
        if (w_d >= 12'd56) begin
            w_shd = '0;
            w_stk = |w_sm_m;
        end else begin
            w_shd = w_ext >> w_d[5:0];
            w_stk = |(w_ext & ~({56{1'b1}} << w_d[5:0]));
        end
        w_sum = {1'b0, w_big_m, 3'b000} + {1'b0, w_shd[55:1], w_shd[0] | w_stk};
    end

    always_comb begin
        w_rr      = round57(r_sum);
        w_e_round = r_e + $signed({10'd0, w_rr.inc});
        if (r_e < 0) begin
            w_sa_tmp = '0;
            w_ip     = '0;
        end else if (r_e >= 12'sd52) begin
            w_sa_tmp = r_e - 12'sd52;
            w_ip     = {11'd0, r_m} << w_sa_tmp[5:0];
        end else begin
            w_sa_tmp = 12'sd52 - r_e;
            w_ip     = {11'd0, r_m} >> w_sa_tmp[5:0];
        end
    end

    // add 3 to every bcd digit of five or more before the shift
    always_comb begin
        for (int k = 0; k < MAX_INT_DIGITS; k++) begin
            w_bcd_adj[4*k +: 4] = (r_bcd[4*k +: 4] >= 4'd5) ? (r_bcd[4*k +: 4] + 4'd3)
                                                              : r_bcd[4*k +: 4];
        end
    end

    always_comb begin
        // fraction bits of the value: drop bits of weight one and above
        w_keep = {53{1'b1}} >> 6'(r_e + 12'sd1);
        w_prod = {1'b0, r_m, 3'b000} + {3'b000, r_m, 1'b0};
        w_mr   = round57(w_prod);
        if ((r_m == 53'd0) || (r_e < 0)) begin
            w_dig_raw = 4'd0;
        end else begin
            w_dig_raw = r_m[52:49] >> (2'd3 - r_e[1:0]);
        end
        w_dig = (w_dig_raw > 4'd9) ? 4'd9 : w_dig_raw;
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_character    = r_char;
    assign o_is_negative  = r_out_neg;
    assign o_out_of_range = r_out_oor;
    assign o_last         = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && !w_emit) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_neg  <= w_in_neg;
                        r_prec <= w_prec;
                        r_m    <= {(w_ef != 11'd0), i_value_bits[51:0]};
                        r_e    <= w_in_e;
                        r_state <= (w_ef == 11'h7FF) ? S_OOR : S_ALIGN;
                    end
                end
                S_ALIGN: begin
                    r_sum   <= w_sum;
                    r_e     <= w_big_e;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_m     <= w_rr.m;
                    r_e     <= w_e_round;
                    r_state <= (w_e_round >= 12'sd64) ? S_OOR : S_IPART;
                end
                S_IPART: begin
                    r_bin   <= w_ip;
                    r_bcd   <= '0;
                    r_cnt   <= 7'd64;
                    r_state <= S_DABBLE;
                end
                S_DABBLE: begin
                    {r_bcd, r_bin} <= {w_bcd_adj, r_bin} << 1;
                    r_cnt <= r_cnt - 7'd1;
                    if (r_cnt == 7'd1) begin
                        r_nd    <= ND_W'(MAX_INT_DIGITS);
                        r_state <= S_SKIP;
                    end
                end
                S_SKIP: begin
                    // leading zeros go, but one digit always stays
                    if ((w_top == 4'd0) && (r_nd > ND_W'(1))) begin
                        r_bcd <= r_bcd << 4;
                        r_nd  <= r_nd - ND_W'(1);
                    end else begin
                        r_state <= S_INT;
                    end
                end
                S_INT: begin
                    if (w_slot) begin
                        r_out_valid <= 1'b1;
                        r_char      <= CHAR_ZERO + {2'b00, w_top};
                        r_out_neg   <= r_neg;
                        r_out_oor   <= 1'b0;
                        r_last      <= 1'b0;
                        r_bcd       <= r_bcd << 4;
                        r_nd        <= r_nd - ND_W'(1);
                        if (r_nd == ND_W'(1)) begin
                            r_state <= S_DOT;
                        end
                    end
                end
                S_DOT: begin
                    if (w_slot) begin
                        r_out_valid <= 1'b1;
                        r_char      <= CHAR_DOT;
                        r_out_neg   <= r_neg;
                        r_out_oor   <= 1'b0;
                        r_last      <= (r_prec == '0);
                        r_j         <= '0;
                        r_state     <= (r_prec == '0) ? S_IDLE : S_FSUB;
                    end
                end
                S_FSUB: begin
                    if (r_e >= 12'sd52) begin
                        r_m <= '0;
                    end else if (r_e >= 0) begin
                        r_m <= r_m & w_keep;
                    end
                    r_state <= S_FNORM;
                end
                S_FNORM: begin
                    if ((r_m == 53'd0) || r_m[52]) begin
                        r_state <= S_FMUL;
                    end else begin
                        r_m <= r_m << 1;
                        r_e <= r_e - 12'sd1;
                    end
                end
                S_FMUL: begin
                    if (r_m != 53'd0) begin
                        r_m <= w_mr.m;
                        r_e <= r_e + 12'sd3 + $signed({10'd0, w_mr.inc});
                    end
                    r_state <= S_FDIG;
                end
                S_FDIG: begin
                    if (w_slot) begin
                        r_out_valid <= 1'b1;
                        r_char      <= CHAR_ZERO + {2'b00, w_dig};
                        r_out_neg   <= r_neg;
                        r_out_oor   <= 1'b0;
                        r_last      <= ((r_j + 1'b1) == r_prec);
                        r_j         <= r_j + 1'b1;
                        r_state     <= ((r_j + 1'b1) == r_prec) ? S_IDLE : S_FSUB;
                    end
                end
                S_OOR: begin
                    if (w_slot) begin
                        r_out_valid <= 1'b1;
                        r_char      <= CHAR_ZERO;
                        r_out_neg   <= r_neg;
                        r_out_oor   <= 1'b1;
                        r_last      <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `DTFD_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready,
        "block still ready after taking a number")
    `DTFD_ASSERT_SAME(a_oor_single_beat, o_out_valid && o_out_of_range,
        o_last && (o_character == CHAR_ZERO), "out-of-range beat is not a lone zero")
    `DTFD_ASSERT_SAME(a_char_code, o_out_valid,
        (o_character == CHAR_DOT) || ((o_character >= CHAR_ZERO) && (o_character <= 6'd57)),
        "character is neither digit nor dot")

endmodule
